@@ rtl/literal_search_replace_stream_core_defines.svh @@
// Assertion macros shared by the literal search and replace stream core.
`ifndef LITERAL_SEARCH_REPLACE_STREAM_CORE_DEFINES_SVH
`define LITERAL_SEARCH_REPLACE_STREAM_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LSR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsr core assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define LSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsr core assertion failed");

`endif

@@ rtl/lsr_pkg.sv @@
// Package with shared types and constants of the literal search and replace core.
package lsr_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_W  = 64;
  localparam int LEN_W  = 4;
  localparam int IDX_W  = 2;

  typedef enum logic [IDX_W-1:0] {
    CFG_PATTERN_BYTES,
    CFG_PATTERN_LENGTH,
    CFG_REPLACEMENT_BYTES,
    CFG_REPLACEMENT_LENGTH
  } cfg_idx_t;

  typedef struct packed {
    logic present;
    logic last;
  } burst_ctl_t;

endpackage

@@ rtl/lsr_in_if.sv @@
// Request channel interface carrying one text byte and its end mark.
interface lsr_in_if;
  logic                       valid;
  logic                       ready;
  logic [lsr_pkg::BYTE_W-1:0] text_byte;
  logic                       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

@@ rtl/lsr_out_if.sv @@
// Request channel interface carrying one byte of the rewritten text.
interface lsr_out_if;
  logic                       valid;
  logic                       ready;
  logic [lsr_pkg::BYTE_W-1:0] out_byte;
  logic                       byte_present;
  logic                       out_end;

  modport source (output valid, output out_byte, output byte_present, output out_end,
                  input ready);
  modport sink (input valid, input out_byte, input byte_present, input out_end,
                output ready);
endinterface

@@ rtl/lsr_window.sv @@
// Lookahead window with parallel pattern compare that forms the result burst of a byte.
module lsr_window #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8,
  parameter int MAX_BURST       = 8,
  parameter int CNT_W           = 4
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         take,
  input  logic                                         flush,
  input  logic [lsr_pkg::BYTE_W-1:0]                   text_byte,
  input  logic                                         text_end,
  input  logic [lsr_pkg::CFG_W-1:0]                    pattern_bytes,
  input  logic [lsr_pkg::LEN_W-1:0]                    pattern_length,
  input  logic [lsr_pkg::CFG_W-1:0]                    replacement_bytes,
  input  logic [lsr_pkg::LEN_W-1:0]                    replacement_length,
  output logic [MAX_BURST-1:0][lsr_pkg::BYTE_W-1:0]    burst_bytes,
  output logic [CNT_W-1:0]                             burst_count,
  output lsr_pkg::burst_ctl_t                          burst_ctl
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN-1:0][lsr_pkg::BYTE_W-1:0] store;
  logic [MAX_PATTERN-1:0][lsr_pkg::BYTE_W-1:0] store_next;
  logic [FILL_W-1:0]                           fill;
  logic [FILL_W-1:0]                           fill_next;

  logic [MAX_PATTERN-1:0][lsr_pkg::BYTE_W-1:0] win;
  logic [MAX_BURST-1:0][lsr_pkg::BYTE_W-1:0]   win_ext;
  logic [MAX_BURST-1:0][lsr_pkg::BYTE_W-1:0]   repl;
  logic [FILL_W-1:0]                           plen;
  logic [CNT_W-1:0]                            rlen;
  logic [FILL_W-1:0]                           fill_inc;
  logic                                        full;
  logic                                        match;
  logic                                        slide;

  always_comb begin
    if (pattern_length == '0) begin
      plen = FILL_W'(1);
    end else if (pattern_length > lsr_pkg::LEN_W'(MAX_PATTERN)) begin
      plen = FILL_W'(MAX_PATTERN);
    end else begin
      plen = FILL_W'(pattern_length);
    end
    if (replacement_length > lsr_pkg::LEN_W'(MAX_REPLACEMENT)) begin
      rlen = CNT_W'(MAX_REPLACEMENT);
    end else begin
      rlen = CNT_W'(replacement_length);
    end
  end

  always_comb begin
    win_ext = '0;
    repl    = '0;
    match   = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win[i] = (FILL_W'(i) == fill) ? text_byte : store[i];
      win_ext[i] = win[i];
      if (FILL_W'(i) < plen && win[i] != pattern_bytes[lsr_pkg::BYTE_W*i +: lsr_pkg::BYTE_W])
      begin
        match = 1'b0;
      end
    end
    for (int i = 0; i < MAX_BURST; i++) begin
      if (i < MAX_REPLACEMENT) begin
        repl[i] = replacement_bytes[lsr_pkg::BYTE_W*i +: lsr_pkg::BYTE_W];
      end
    end
    fill_inc = fill + FILL_W'(1);
    full     = (fill_inc == plen);
    slide    = full && !match;
  end

  always_comb begin
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      store_next[i] = slide ? win[i+1] : win[i];
    end
    store_next[MAX_PATTERN-1] = win[MAX_PATTERN-1];

    if (text_end || (full && match)) begin
      fill_next = '0;
    end else if (full) begin
      fill_next = plen - FILL_W'(1);
    end else begin
      fill_next = fill_inc;
    end

    burst_ctl.present = 1'b1;
    burst_ctl.last    = text_end;
    if (full && match) begin
      burst_bytes = repl;
      burst_count = rlen;
      if (text_end && rlen == '0) begin
        burst_count       = CNT_W'(1);
        burst_ctl.present = 1'b0;
      end
    end else begin
      burst_bytes = win_ext;
      if (full) begin
        burst_count = text_end ? CNT_W'(plen) : CNT_W'(1);
      end else begin
        burst_count = text_end ? CNT_W'(fill_inc) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      fill <= '0;
    end else if (take) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      store <= store_next;
    end
  end

endmodule

@@ rtl/lsr_drain.sv @@
// Result register that holds one burst and hands its bytes out one per cycle while out_ch is ready.
`include "literal_search_replace_stream_core_defines.svh"

module lsr_drain #(
  parameter int MAX_BURST = 8,
  parameter int CNT_W     = 4
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      load,
  input  logic [MAX_BURST-1:0][lsr_pkg::BYTE_W-1:0] burst_bytes,
  input  logic [CNT_W-1:0]                          burst_count,
  input  lsr_pkg::burst_ctl_t                       burst_ctl,
  output logic                                      can_load,
  lsr_out_if.source                                 out_ch
);

  logic [MAX_BURST-1:0][lsr_pkg::BYTE_W-1:0] bytes;
  logic [CNT_W-1:0]                          remaining;
  lsr_pkg::burst_ctl_t                       ctl;
  logic                                      fire;

  assign fire                = out_ch.valid && out_ch.ready;
  assign out_ch.valid        = (remaining != '0);
  assign out_ch.out_byte     = ctl.present ? bytes[0] : '0;
  assign out_ch.byte_present = ctl.present;
  assign out_ch.out_end      = ctl.last && (remaining == CNT_W'(1));
  assign can_load            = (remaining == '0) || (remaining == CNT_W'(1) && out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load) begin
      remaining <= burst_count;
    end else if (fire) begin
      remaining <= remaining - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= burst_bytes;
      ctl   <= burst_ctl;
    end else if (fire) begin
      for (int i = 0; i < MAX_BURST - 1; i++) begin
        bytes[i] <= bytes[i+1];
      end
    end
  end

  `LSR_ASSERT_NEXT(a_load_count, clk, rst, load, remaining == $past(burst_count))
  `LSR_ASSERT_NEXT(a_shift, clk, rst, fire && !load && remaining > CNT_W'(1),
    bytes[0] == $past(bytes[1]) && remaining == $past(remaining) - CNT_W'(1))
  `LSR_ASSERT_SAME(a_bare_end, clk, rst, out_ch.valid && !ctl.present,
    remaining == CNT_W'(1) && ctl.last)
  `LSR_ASSERT_SAME(a_no_overrun, clk, rst, load, can_load)

endmodule

@@ rtl/literal_search_replace_stream_core.sv @@
// Top level of the streaming literal search and replace core.
//
// The in_ch channel takes one text byte per request, with text_end set on the
// last byte of a text. The out_ch channel returns the rewritten text one byte
// per request; byte_present is low only on a bare end mark and out_end is set
// on the final result of a text. Registers are written through cfg_we,
// cfg_index and cfg_data while the core is idle, a rule that binds the user
// and that the core does not enforce; writing the pattern length discards
// the bytes held in the lookahead window. A byte is compared against the
// pattern in the cycle it is accepted, and its results appear on out_ch from
// the next cycle, one per cycle. A byte that yields at most one result is
// accepted every cycle; one that yields more holds the input until out_ch
// is ready for its last result. Reset clears the window and the result
// register and loads the register defaults (pattern length one, empty
// replacement). When out_ch stalls, the current result holds and in_ch
// takes no byte until the last result of the current burst is accepted.
module literal_search_replace_stream_core #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lsr_pkg::IDX_W-1:0]    cfg_index,
  input  logic [lsr_pkg::CFG_W-1:0]    cfg_data,
  lsr_in_if.sink                       in_ch,
  lsr_out_if.source                    out_ch
);

  localparam int MAX_BURST = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int CNT_W     = $clog2(MAX_BURST + 1);

  logic [lsr_pkg::CFG_W-1:0]                 pattern_bytes;
  logic [lsr_pkg::LEN_W-1:0]                 pattern_length;
  logic [lsr_pkg::CFG_W-1:0]                 replacement_bytes;
  logic [lsr_pkg::LEN_W-1:0]                 replacement_length;
  logic                                      flush;
  logic                                      take;
  logic                                      can_load;
  logic [MAX_BURST-1:0][lsr_pkg::BYTE_W-1:0] burst_bytes;
  logic [CNT_W-1:0]                          burst_count;
  lsr_pkg::burst_ctl_t                       burst_ctl;

  assign in_ch.ready = can_load;
  assign take        = in_ch.valid && can_load;
  assign flush       = cfg_we && (cfg_index == lsr_pkg::CFG_PATTERN_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= lsr_pkg::LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_we) begin
      unique case (lsr_pkg::cfg_idx_t'(cfg_index))
        lsr_pkg::CFG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        lsr_pkg::CFG_PATTERN_LENGTH:     pattern_length     <= cfg_data[lsr_pkg::LEN_W-1:0];
        lsr_pkg::CFG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        lsr_pkg::CFG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[lsr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  lsr_window #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT),
    .MAX_BURST       (MAX_BURST),
    .CNT_W           (CNT_W)
  ) u_window (
    .clk                (clk),
    .rst                (rst),
    .take               (take),
    .flush              (flush),
    .text_byte          (in_ch.text_byte),
    .text_end           (in_ch.text_end),
    .pattern_bytes      (pattern_bytes),
    .pattern_length     (pattern_length),
    .replacement_bytes  (replacement_bytes),
    .replacement_length (replacement_length),
    .burst_bytes        (burst_bytes),
    .burst_count        (burst_count),
    .burst_ctl          (burst_ctl)
  );

  lsr_drain #(
    .MAX_BURST (MAX_BURST),
    .CNT_W     (CNT_W)
  ) u_drain (
    .clk         (clk),
    .rst         (rst),
    .load        (take),
    .burst_bytes (burst_bytes),
    .burst_count (burst_count),
    .burst_ctl   (burst_ctl),
    .can_load    (can_load),
    .out_ch      (out_ch)
  );

endmodule
